FILE: hdl/go_back_n_sender_window_unit_assert.svh
// Assertion macros shared by the go-back-N sender checker
`ifndef GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH
`define GO_BACK_N_SENDER_WINDOW_UNIT_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define GBN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gbn: same-cycle check failed");

// next-cycle implication, disabled while reset is low
`define GBN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gbn: next-cycle check failed");

`endif

FILE: hdl/gbn_pkg.sv
// Types and constants of the go-back-N sender window unit
package gbn_pkg;

  localparam int SEQ_W   = 10;
  localparam int BYTES_W = 16;
  localparam int WIN_W   = 6;
  localparam int LEN_W   = 8;
  localparam int CMD_W   = 2;
  localparam int CNT_W   = 6;
  localparam int CFG_ADDR_W = 1;

  localparam logic [SEQ_W-1:0] SEQ_LIMIT    = 10'd1023;
  localparam logic [CNT_W-1:0] RESULT_LIMIT = 6'd32;
  localparam logic [WIN_W-1:0] WIN_HW_MAX   = 6'd63;
  localparam logic [WIN_W-1:0] WIN_RESET    = 6'd3;

  // event codes
  localparam logic [CMD_W-1:0] CMD_START   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACK     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NONE    = 2'd3;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_TOTAL_BYTES = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_INIT_WINDOW = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SEQ_W-1:0] ack_seq;
  } gbn_in_t;

  typedef struct packed {
    logic [SEQ_W-1:0]   frame_seq;
    logic [BYTES_W-1:0] byte_offset;
    logic [LEN_W-1:0]   frame_len;
    logic               last_of_run;
    logic               transfer_done;
  } gbn_out_t;

  // classified event passed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] ack_seq;
    logic             ack_final;  // ack names the final frame
    logic [WIN_W-1:0] load_win;   // clamped start window
  } gbn_evt_t;

endpackage

FILE: hdl/gbn_fifo.sv
// Small synchronous FIFO
module gbn_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hdl/gbn_front.sv
// Front end: takes requests, classifies them and precomputes ack offsets
module gbn_front
  import gbn_pkg::*;
#(
  parameter int CHUNK_BYTES = 190,
  parameter int WINDOW_MAX  = 32,
  parameter int OFF_W       = 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  gbn_in_t            in_item,
  input  logic [BYTES_W-1:0] total_bytes,
  input  logic [WIN_W-1:0]   init_window,
  input  logic               evt_full,
  output logic               evt_push,
  output gbn_evt_t           evt,
  output logic [OFF_W-1:0]   evt_off
);

  localparam int CMP_W = (OFF_W > BYTES_W) ? OFF_W : BYTES_W;
  localparam int WIN_CAP_I = (WINDOW_MAX > 63) ? 63 : ((WINDOW_MAX < 1) ? 1 : WINDOW_MAX);
  localparam logic [WIN_W-1:0] WIN_CAP   = WIN_W'(WIN_CAP_I);
  localparam logic [OFF_W-1:0] CHUNK_OFF = OFF_W'(CHUNK_BYTES);

  logic               hold_vld_r;
  gbn_in_t            hold_r;
  logic               leave, take;
  logic [OFF_W-1:0]   ack_off, ack_next;
  logic [CMP_W-1:0]   tb;
  logic               in_range, is_last;
  logic [WIN_W-1:0]   load_win;

  assign tb       = CMP_W'(total_bytes);
  assign ack_off  = OFF_W'(hold_r.ack_seq) * CHUNK_OFF;
  assign ack_next = ack_off + CHUNK_OFF;

  // ack < frame count, and ack + 1 >= frame count (count saturates at SEQ_LIMIT)
  assign in_range = (hold_r.ack_seq != SEQ_LIMIT) && (CMP_W'(ack_off) < tb);
  assign is_last  = (CMP_W'(ack_next) >= tb) || (hold_r.ack_seq == SEQ_LIMIT - SEQ_W'(1));

  always_comb begin
    if (init_window == '0) begin
      load_win = WIN_W'(1);
    end else if (init_window > WIN_CAP) begin
      load_win = WIN_CAP;
    end else begin
      load_win = init_window;
    end
  end

  // unused command code is dropped here
  assign leave    = hold_vld_r && ((hold_r.command == CMD_NONE) || !evt_full);
  assign evt_push = hold_vld_r && (hold_r.command != CMD_NONE) && !evt_full;
  assign in_full  = hold_vld_r && !leave;
  assign take     = in_push && !in_full;

  assign evt.cmd       = hold_r.command;
  assign evt.ack_seq   = hold_r.ack_seq;
  assign evt.ack_final = in_range && is_last;
  assign evt.load_win  = load_win;
  assign evt_off       = ack_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (take) begin
      hold_vld_r <= 1'b1;
    end else if (leave) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hold_r <= in_item;
    end
  end

endmodule

FILE: hdl/gbn_back.sv
// Back end: window state and descriptor sequencer, one descriptor per cycle unless the result queue is full
module gbn_back
  import gbn_pkg::*;
#(
  parameter int CHUNK_BYTES = 190,
  parameter int WINDOW_MAX  = 32,
  parameter int OFF_W       = 19
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               evt_empty,
  output logic               evt_pop,
  input  gbn_evt_t           evt,
  input  logic [OFF_W-1:0]   evt_off,
  input  logic [BYTES_W-1:0] total_bytes,
  input  logic               res_full,
  output logic               res_push,
  output gbn_out_t           res
);

  localparam int CMP_W = (OFF_W > BYTES_W) ? OFF_W : BYTES_W;
  localparam int WIN_CAP_I = (WINDOW_MAX > 63) ? 63 : ((WINDOW_MAX < 1) ? 1 : WINDOW_MAX);
  localparam logic [WIN_W-1:0] WIN_CAP   = WIN_W'(WIN_CAP_I);
  localparam logic [CMP_W-1:0] CHUNK_CMP = CMP_W'(CHUNK_BYTES);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t             state_r, state_nxt;
  logic [SEQ_W-1:0]   next_seq_r, next_seq_nxt;
  logic [SEQ_W-1:0]   base_r, base_nxt;
  logic [WIN_W-1:0]   win_r, win_nxt;
  logic               fin_r, fin_nxt;
  logic [OFF_W-1:0]   off_r, off_nxt;
  logic [OFF_W-1:0]   base_off_r, base_off_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;

  logic [SEQ_W:0]     win_end, seq_ext, seq_inc, ack_inc;
  logic [CMP_W-1:0]   tb, off_c, off_step, remain, len;
  logic [WIN_W-1:0]   win_half;
  logic               can_send, more;

  assign tb       = CMP_W'(total_bytes);
  assign off_c    = CMP_W'(off_r);
  assign off_step = off_c + CHUNK_CMP;
  assign remain   = tb - off_c;
  assign len      = (remain < CHUNK_CMP) ? remain : CHUNK_CMP;
  assign win_end  = (SEQ_W+1)'(base_r) + (SEQ_W+1)'(win_r);
  assign seq_ext  = (SEQ_W+1)'(next_seq_r);
  assign seq_inc  = seq_ext + (SEQ_W+1)'(1);
  assign ack_inc  = (SEQ_W+1)'(evt.ack_seq) + (SEQ_W+1)'(1);
  assign win_half = win_r >> 1;

  // current frame admitted, and whether the one after it will be
  assign can_send = (cnt_r < RESULT_LIMIT) && (seq_ext < win_end) &&
                    (next_seq_r != SEQ_LIMIT) && (off_c < tb);
  assign more     = (cnt_r + CNT_W'(1) < RESULT_LIMIT) && (seq_inc < win_end) &&
                    (next_seq_r != SEQ_LIMIT - SEQ_W'(1)) && (off_step < tb);

  always_comb begin
    state_nxt    = state_r;
    next_seq_nxt = next_seq_r;
    base_nxt     = base_r;
    win_nxt      = win_r;
    fin_nxt      = fin_r;
    off_nxt      = off_r;
    base_off_nxt = base_off_r;
    cnt_nxt      = cnt_r;
    evt_pop      = 1'b0;
    res_push     = 1'b0;
    res.frame_seq     = next_seq_r;
    res.byte_offset   = off_c[BYTES_W-1:0];
    res.frame_len     = len[LEN_W-1:0];
    res.last_of_run   = !more;
    res.transfer_done = fin_r;

    unique case (state_r)
      S_IDLE: begin
        if (!evt_empty) begin
          evt_pop   = 1'b1;
          cnt_nxt   = '0;
          state_nxt = S_EMIT;
          unique case (evt.cmd)
            CMD_START: begin
              next_seq_nxt = '0;
              base_nxt     = '0;
              win_nxt      = evt.load_win;
              fin_nxt      = 1'b0;
              off_nxt      = '0;
              base_off_nxt = '0;
            end
            CMD_ACK: begin
              if (evt.ack_seq < next_seq_r) begin
                if (ack_inc > (SEQ_W+1)'(base_r)) begin
                  base_nxt     = ack_inc[SEQ_W-1:0];
                  base_off_nxt = evt_off;
                end
                if (win_r < WIN_CAP) begin
                  win_nxt = win_r + WIN_W'(1);
                end
                fin_nxt = fin_r | evt.ack_final;
              end
            end
            CMD_TIMEOUT: begin
              next_seq_nxt = base_r;
              off_nxt      = base_off_r;
              win_nxt      = (win_half == '0) ? WIN_W'(1) : win_half;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_EMIT: begin
        if (can_send) begin
          if (!res_full) begin
            res_push     = 1'b1;
            next_seq_nxt = next_seq_r + SEQ_W'(1);
            off_nxt      = off_step[OFF_W-1:0];
            cnt_nxt      = cnt_r + CNT_W'(1);
            if (!more) begin
              state_nxt = S_IDLE;
            end
          end
        end else if (cnt_r == '0 && fin_r) begin
          // completion report
          res.frame_seq   = '0;
          res.byte_offset = '0;
          res.frame_len   = '0;
          res.last_of_run = 1'b1;
          if (!res_full) begin
            res_push  = 1'b1;
            state_nxt = S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      next_seq_r <= '0;
      base_r     <= '0;
      win_r      <= WIN_RESET;
      fin_r      <= 1'b0;
      off_r      <= '0;
      base_off_r <= '0;
      cnt_r      <= '0;
    end else begin
      state_r    <= state_nxt;
      next_seq_r <= next_seq_nxt;
      base_r     <= base_nxt;
      win_r      <= win_nxt;
      fin_r      <= fin_nxt;
      off_r      <= off_nxt;
      base_off_r <= base_off_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

endmodule

FILE: hdl/go_back_n_sender_window_unit.sv
// Top level of the go-back-N sender window unit
//
//   channel  ports                            moves
//   in       in_push / in_full / in_item      one event request (start, ack, timeout)
//   out      out_empty / out_pop / out_item   one frame descriptor or completion report
//   cfg      cfg_we / cfg_addr / cfg_wdata    total_bytes (0), initial_window (1)
//
// An event request is held in the front register and passes through the event
// queue; the back end applies it to the window, then emits its descriptors one
// per cycle unless the result queue is full (k results per event, k up to 32).
// Reset (rst_n low, synchronous) clears both queues and the window state.
// The event queue lets the front keep taking requests while the back end is
// blocked on a full result queue.
module go_back_n_sender_window_unit
  import gbn_pkg::*;
#(
  parameter int CHUNK_BYTES = 190,
  parameter int WINDOW_MAX  = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  gbn_in_t               in_item,
  output logic                  out_empty,
  input  logic                  out_pop,
  output gbn_out_t              out_item,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [BYTES_W-1:0]    cfg_wdata
);

  // offsets up to (1023 + 1) * CHUNK_BYTES
  localparam int OFF_W   = SEQ_W + 1 + $clog2(CHUNK_BYTES);
  localparam int EVT_W   = $bits(gbn_evt_t) + OFF_W;
  localparam int OUT_W   = $bits(gbn_out_t);

  logic [BYTES_W-1:0] total_bytes_r;
  logic [WIN_W-1:0]   init_win_r;

  // front -> event queue
  logic               evt_push, evt_full;
  gbn_evt_t           evt_in;
  logic [OFF_W-1:0]   evt_off_in;
  // event queue -> back
  logic               evt_pop, evt_empty;
  logic [EVT_W-1:0]   evt_rdata;
  gbn_evt_t           evt_out;
  logic [OFF_W-1:0]   evt_off_out;
  // back -> result queue
  logic               res_push, res_full;
  gbn_out_t           res;
  logic [OUT_W-1:0]   res_rdata;

  // config registers, to be written only while idle; the block itself does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_bytes_r <= '0;
      init_win_r    <= WIN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_TOTAL_BYTES: total_bytes_r <= cfg_wdata;
        REG_INIT_WINDOW: init_win_r    <= cfg_wdata[WIN_W-1:0];
        default: ;
      endcase
    end
  end

  gbn_front #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .WINDOW_MAX  (WINDOW_MAX),
    .OFF_W       (OFF_W)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_item     (in_item),
    .total_bytes (total_bytes_r),
    .init_window (init_win_r),
    .evt_full    (evt_full),
    .evt_push    (evt_push),
    .evt         (evt_in),
    .evt_off     (evt_off_in)
  );

  gbn_fifo #(
    .WIDTH (EVT_W),
    .DEPTH (2)
  ) u_evt_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (evt_push),
    .wdata ({evt_in, evt_off_in}),
    .full  (evt_full),
    .pop   (evt_pop),
    .rdata (evt_rdata),
    .empty (evt_empty)
  );

  assign evt_out     = evt_rdata[EVT_W-1:OFF_W];
  assign evt_off_out = evt_rdata[OFF_W-1:0];

  gbn_back #(
    .CHUNK_BYTES (CHUNK_BYTES),
    .WINDOW_MAX  (WINDOW_MAX),
    .OFF_W       (OFF_W)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_empty   (evt_empty),
    .evt_pop     (evt_pop),
    .evt         (evt_out),
    .evt_off     (evt_off_out),
    .total_bytes (total_bytes_r),
    .res_full    (res_full),
    .res_push    (res_push),
    .res         (res)
  );

  // result queue parts the sequencer from the consumer
  gbn_fifo #(
    .WIDTH (OUT_W),
    .DEPTH (4)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_rdata),
    .empty (out_empty)
  );

  assign out_item = res_rdata;

endmodule

FILE: hdl/gbn_checker.sv
// Port-level checks for the go-back-N sender window unit, with its bind
`include "go_back_n_sender_window_unit_assert.svh"

module gbn_checker
  import gbn_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_full,
  input logic                  out_empty,
  input logic                  out_pop,
  input gbn_out_t              out_item
);

  // both sides come out of reset empty
  `GBN_ASSERT_IMP(a_rst_in_open, clk, rst_n, $past(!rst_n), !in_full)
  `GBN_ASSERT_IMP(a_rst_out_empty, clk, rst_n, $past(!rst_n), out_empty)

  // a waiting result holds until taken
  `GBN_ASSERT_NXT(a_out_hold, clk, rst_n, !out_empty && !out_pop,
                  !out_empty && $stable(out_item))

  // within a run, descriptors follow back to back with consecutive sequence numbers
  `GBN_ASSERT_NXT(a_run_next, clk, rst_n, out_pop && !out_empty && !out_item.last_of_run,
                  !out_empty && (out_item.frame_seq == $past(out_item.frame_seq) + 10'd1))

endmodule

bind go_back_n_sender_window_unit gbn_checker u_gbn_checker (.*);
